// File: design/oeg_pkg.sv
// shared constants and codes for the obstacle evidence grid
package oeg_pkg;
	localparam int MapBitsDef   = 8;
	localparam int RingDepthDef = 1024;
	localparam int UnexCodeDef  = 255;

	typedef enum logic [2:0] {
		OP_MARK_OBST = 3'd0,
		OP_MARK_FREE = 3'd1,
		OP_TICK      = 3'd2,
		OP_PROTECT   = 3'd3,
		OP_UNPROTECT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_REJECT = 2'd0,
		ST_DONE   = 2'd1,
		ST_AGAIN  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_MOD   = 5'b00100,
		S_RING  = 5'b01000,
		S_GRID  = 5'b10000
	} state_t;
endpackage

// File: design/oeg_grid_mem.sv
// grid memory: protect bit and evidence count per cell
module oeg_grid_mem import oeg_pkg::*; #(
	parameter int MAP_BITS = MapBitsDef
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [2*MAP_BITS-1:0] waddr,
	input  logic [8:0]            wdata,
	input  logic [2*MAP_BITS-1:0] raddr,
	output logic [8:0]            rdata
);
	logic [8:0] mem [2**(2*MAP_BITS)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/oeg_ring_mem.sv
// transient ring memory: cell index and timestamp per entry
module oeg_ring_mem import oeg_pkg::*; #(
	parameter int MAP_BITS   = MapBitsDef,
	parameter int RING_DEPTH = RingDepthDef
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(RING_DEPTH)-1:0] waddr,
	input  logic [2*MAP_BITS+31:0]        wdata,
	input  logic [$clog2(RING_DEPTH)-1:0] raddr,
	output logic [2*MAP_BITS+31:0]        rdata
);
	logic [2*MAP_BITS+31:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/obstacle_evidence_grid_top.sv
// obstacle evidence grid: control, ring pointers, tick counter
// marks, protect, unprotect: an accepted item passes through S_MOD, which registers its done strobe; busy meanwhile
// tick: S_RING and S_GRID alternate for each expired ring entry (ring read then grid read-modify-write)
// a new item is accepted only once the last one is done; busy interlocks every grid read-modify-write
// after reset a clearing pass writes every cell, with busy high
// done is a one-cycle strobe; the receiver cannot stall
module obstacle_evidence_grid_top import oeg_pkg::*; #(
	parameter int MAP_BITS        = MapBitsDef,
	parameter int RING_DEPTH      = RingDepthDef,
	parameter int UNEXPLORED_CODE = UnexCodeDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic signed [15:0] cell_x,
	input  logic signed [15:0] cell_y,
	input  logic [7:0]  strength,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [7:0]  cell_value,
	output logic        became_free,
	output logic [10:0] expired_count
);
	localparam int CB = 2 * MAP_BITS;
	localparam int PB = $clog2(RING_DEPTH);
	localparam logic [7:0] UNEX = 8'(UNEXPLORED_CODE);
	localparam logic [7:0] PERM = 8'(UNEXPLORED_CODE - 1);
	localparam logic [7:0] SATV = 8'(UNEXPLORED_CODE - 2);
	localparam logic [PB-1:0] LAST = PB'(RING_DEPTH - 1);

	state_t        state_q;
	logic [2:0]    op_q;
	logic          inside_q;
	logic [CB-1:0] idx_q;
	logic [7:0]    str_q;
	logic [PB-1:0] head_q, tail_q;
	logic [31:0]   tick_q;
	logic [15:0]   delay_q;
	logic [10:0]   freed_q;
	logic [CB-1:0] clr_q;

	logic          accept, in_inside;
	logic [CB-1:0] in_idx;
	logic          gwe;
	logic [CB-1:0] gwaddr, graddr;
	logic [8:0]    gwdata, grd;
	logic          rwe;
	logic [CB+31:0] rrd;
	logic [CB-1:0] r_idx;
	logic [31:0]   r_stamp;
	logic [PB-1:0] tail_nx, head_nx;
	logic          full, expire;
	logic [7:0]    v, nv, vv;
	logic          prot;
	logic [8:0]    sum;
	logic [1:0]    st_n;
	logic [7:0]    cell_n;
	logic          bf_n, mod_we;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign in_inside = !cell_x[15] && !cell_y[15] &&
		((cell_x[14:0] >> MAP_BITS) == 15'd0) && ((cell_y[14:0] >> MAP_BITS) == 15'd0);
	assign in_idx    = {cell_y[MAP_BITS-1:0], cell_x[MAP_BITS-1:0]};
	assign r_idx     = rrd[CB+31:32];
	assign r_stamp   = rrd[31:0];
	assign tail_nx   = (tail_q == LAST) ? '0 : tail_q + PB'(1);
	assign head_nx   = (head_q == LAST) ? '0 : head_q + PB'(1);
	assign full      = (tail_nx == head_q);
	assign expire    = (head_q != tail_q) && ((tick_q - r_stamp) > {16'd0, delay_q});
	assign v         = grd[7:0];
	assign prot      = grd[8];
	assign vv        = (v == UNEX) ? 8'd0 : v;
	assign sum       = {1'b0, v} + {1'b0, str_q};

	// read-modify-write of one cell
	always_comb begin
		nv     = v;
		st_n   = ST_REJECT;
		cell_n = 8'd0;
		bf_n   = 1'b0;
		mod_we = 1'b0;
		rwe    = 1'b0;
		if (inside_q) begin
			unique case (op_q)
				OP_PROTECT, OP_UNPROTECT: begin
					mod_we = 1'b1;
					st_n   = ST_DONE;
					cell_n = v;
				end
				OP_MARK_OBST: begin
					cell_n = v;
					if (!prot) begin
						if (v == 8'd0 || v == UNEX) begin
							if (str_q != 8'd255) begin
								if (full) begin
									st_n = ST_FULL;
								end else begin
									rwe    = 1'b1;
									mod_we = 1'b1;
									nv     = (str_q > SATV) ? SATV : str_q;
									st_n   = ST_DONE;
								end
							end else begin
								mod_we = 1'b1;
								nv     = PERM;
								st_n   = ST_DONE;
							end
						end else begin
							mod_we = 1'b1;
							st_n   = ST_AGAIN;
							if (str_q != 8'd255) begin
								nv = (sum > {1'b0, SATV}) ? SATV : sum[7:0];
							end else begin
								nv = PERM;
							end
						end
						cell_n = nv;
					end
				end
				OP_MARK_FREE: begin
					cell_n = v;
					if (!prot) begin
						mod_we = 1'b1;
						st_n   = ST_DONE;
						if (str_q >= vv) begin
							nv   = 8'd0;
							bf_n = 1'b1;
						end else begin
							nv = vv - str_q;
						end
						cell_n = nv;
					end
				end
				default: begin
					mod_we = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		gwe    = 1'b0;
		gwaddr = idx_q;
		gwdata = {prot, nv};
		graddr = in_idx;
		unique case (state_q)
			S_CLEAR: begin
				gwe    = 1'b1;
				gwaddr = clr_q;
				gwdata = {1'b0, UNEX};
			end
			S_MOD: begin
				gwe = (state_q == S_MOD) && mod_we;
				if (op_q == OP_PROTECT) begin
					gwdata = {1'b1, v};
				end else if (op_q == OP_UNPROTECT) begin
					gwdata = {1'b0, v};
				end
			end
			S_RING: begin
				graddr = r_idx;
			end
			S_GRID: begin
				gwe    = (v != 8'd0) && (v < PERM) && !prot;
				gwdata = 9'd0;
			end
			default: begin
				graddr = in_idx;
			end
		endcase
	end

	oeg_grid_mem #(.MAP_BITS(MAP_BITS)) u_grid (
		.clk   (clk),
		.we    (gwe),
		.waddr (gwaddr),
		.wdata (gwdata),
		.raddr (graddr),
		.rdata (grd)
	);

	oeg_ring_mem #(.MAP_BITS(MAP_BITS), .RING_DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (rwe && (state_q == S_MOD)),
		.waddr (tail_q),
		.wdata ({idx_q, tick_q}),
		.raddr (head_q),
		.rdata (rrd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			tick_q        <= 32'd0;
			delay_q       <= 16'd1000;
			freed_q       <= 11'd0;
			done          <= 1'b0;
			status        <= 2'd0;
			cell_value    <= 8'd0;
			became_free   <= 1'b0;
			expired_count <= 11'd0;
		end else begin
			done <= 1'b0;
			if (cfg_we && cfg_wdata != 16'd0) begin
				delay_q <= cfg_wdata;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CB'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						freed_q <= 11'd0;
						state_q <= (operation == OP_TICK) ? S_RING : S_MOD;
					end
				end
				S_MOD: begin
					if (rwe) begin
						tail_q <= tail_nx;
					end
					done          <= 1'b1;
					status        <= st_n;
					cell_value    <= cell_n;
					became_free   <= bf_n;
					expired_count <= 11'd0;
					state_q       <= S_IDLE;
				end
				S_RING: begin
					if (expire) begin
						head_q  <= head_nx;
						state_q <= S_GRID;
					end else begin
						tick_q        <= tick_q + 32'd1;
						done          <= 1'b1;
						status        <= ST_DONE;
						cell_value    <= 8'd0;
						became_free   <= 1'b0;
						expired_count <= freed_q;
						state_q       <= S_IDLE;
					end
				end
				S_GRID: begin
					if (gwe && freed_q != '1) begin
						freed_q <= freed_q + 11'd1;
					end
					state_q <= S_RING;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			inside_q <= in_inside;
			idx_q    <= in_idx;
			str_q    <= strength;
		end else if (state_q == S_RING) begin
			idx_q <= r_idx;
		end
	end

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_MOD) || ($past(state_q) == S_RING))
		else $error("done without a finishing state");
	a_ring_room: assert property (@(posedge clk) disable iff (!arst_n)
		(rwe && state_q == S_MOD) |=> (tail_q != head_q))
		else $error("ring push overran the head");
	a_no_idle_wr: assert property (@(posedge clk) disable iff (!arst_n)
		gwe |-> (state_q != S_IDLE))
		else $error("grid write while idle");
endmodule
